[rtl/core/assert_macros.svh]
// Assertion macros shared by the simplifier RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition always holds outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

[rtl/core/pss_pkg.sv]
// Shared types and constants of the polyline slope simplifier.
// No dependencies; used by pss_div and polyline_slope_simplifier_unit.
`default_nettype none

package pss_pkg;

	localparam int DEN_W   = 16;
	localparam int QUO_W   = 24;
	localparam int CNT_W   = 5;
	localparam int RATIO_W = 17;
	localparam int MULT_W  = 16;
	localparam int RUN_W   = 16;

	localparam logic [RUN_W-1:0]   RUN_MAX        = 16'hFFFF;
	localparam logic [MULT_W-1:0]  TOL_MULT_RESET = 16'd256;
	localparam logic [CNT_W-1:0]   RATIO_ITERS    = 5'd16;
	localparam logic [CNT_W-1:0]   TOL_ITERS      = 5'd24;
	localparam logic [RATIO_W-1:0] RATIO_ONE      = 17'h10000;

	typedef struct packed {
		logic [DEN_W-1:0] rem_init;
		logic [QUO_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [CNT_W-1:0] iters;
	} div_req_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RDIV  = 6'b000010,
		S_RWAIT = 6'b000100,
		S_TDIV  = 6'b001000,
		S_TWAIT = 6'b010000,
		S_CHECK = 6'b100000
	} pss_state_t;

endpackage

`default_nettype wire

[rtl/core/polyline_slope_simplifier_unit.sv]
// Top level of the polyline slope simplifier: point intake, sequencer, output register.
// Depends on pss_pkg, pss_div and assert_macros.svh.
//
// Usage:
// Points enter on the in channel (x_coord, y_coord, first_point) with valid/ready; kept
// vertices leave on the out channel (vertex_x, vertex_y). A beat is moved when valid and
// ready are both high. tolerance_mult is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this. A first point
// becomes the new anchor and its vertex is shown in the cycle after it is accepted. A point
// equal to the anchor updates only the last point and the run length and leaves the block
// idle. Any other point runs up to two divisions on one shared restoring divider (16 and 24
// quotient bits, one bit per cycle): a diagonal step skips the ratio division, and a run one
// point long skips the tolerance division. The steps are ratio division, wait, tolerance
// division, wait and check. At most one vertex results.
// in_ready is low while a point is being worked on, and also while a finished vertex
// waits in the output register and out_ready is low, so a stalled receiver stalls intake.
// The output register holds its beat until out_ready is seen.
// Reset clears the anchor and last point to (0,0), drops the reference ratio, clears the
// run length and sets tolerance_mult to 256.

`default_nettype none

module polyline_slope_simplifier_unit
	import pss_pkg::*;
#(
	parameter int COORD_BITS = 12
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [MULT_W-1:0]     cfg_wr_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_BITS-1:0] x_coord,
	input  wire logic [COORD_BITS-1:0] y_coord,
	input  wire logic                  first_point,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [COORD_BITS-1:0]      vertex_x,
	output logic [COORD_BITS-1:0]      vertex_y
);

	`include "assert_macros.svh"

	localparam int CMP_W = QUO_W + 1;

	pss_state_t state_q;

	logic [MULT_W-1:0]     mult_q;
	logic [COORD_BITS-1:0] anchor_x_q, anchor_y_q;
	logic [COORD_BITS-1:0] last_x_q, last_y_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [COORD_BITS-1:0] mx_q, mn_q;
	logic [RATIO_W-1:0]    ref_q;
	logic                  present_q;
	logic [RUN_W-1:0]      run_q;
	logic [RATIO_W-1:0]    ratio_q;
	logic [QUO_W-1:0]      tol_q;
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] vertex_x_q, vertex_y_q;

	logic                  accept;
	logic                  vertex_load;
	logic [COORD_BITS-1:0] dx, dy, mx, mn;
	logic [RUN_W-1:0]      run_next;
	logic [RATIO_W-1:0]    ref_sel;
	logic [CMP_W-1:0]      lo_sum, hi_sum;
	logic                  brk;

	logic                  div_start;
	div_req_t              div_req;
	logic                  div_busy;
	logic                  div_done;
	logic [QUO_W-1:0]      div_quo;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign dx = (x_coord > anchor_x_q) ? x_coord - anchor_x_q : anchor_x_q - x_coord;
	assign dy = (y_coord > anchor_y_q) ? y_coord - anchor_y_q : anchor_y_q - y_coord;
	assign mx = (dx > dy) ? dx : dy;
	assign mn = (dx > dy) ? dy : dx;

	assign run_next = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;

	assign ref_sel = present_q ? ref_q : ratio_q;
	assign lo_sum  = CMP_W'(ratio_q) + CMP_W'(tol_q);
	assign hi_sum  = CMP_W'(ref_sel) + CMP_W'(tol_q);
	assign brk     = (lo_sum < CMP_W'(ref_sel)) || (CMP_W'(ratio_q) > hi_sum);

	assign vertex_load = (accept && first_point) || (state_q == S_CHECK && brk);

	always_comb begin
		div_start = 1'b0;
		div_req   = '0;
		unique case (state_q)
			S_RDIV: begin
				div_start        = 1'b1;
				div_req.rem_init = DEN_W'(mn_q);
				div_req.num      = '0;
				div_req.den      = DEN_W'(mx_q);
				div_req.iters    = RATIO_ITERS;
			end
			S_TDIV: begin
				div_start        = (run_q > RUN_W'(1));
				div_req.rem_init = '0;
				div_req.num      = {mult_q, 8'h00};
				div_req.den      = run_q - 1'b1;
				div_req.iters    = TOL_ITERS;
			end
			S_IDLE, S_RWAIT, S_TWAIT, S_CHECK: begin
			end
			default: begin
			end
		endcase
	end

	pss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mult_q      <= TOL_MULT_RESET;
			anchor_x_q  <= '0;
			anchor_y_q  <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			ref_q       <= '0;
			present_q   <= 1'b0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mult_q <= cfg_wr_data;
			end
			out_valid_q <= vertex_load || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept && first_point) begin
						anchor_x_q  <= x_coord;
						anchor_y_q  <= y_coord;
						last_x_q    <= x_coord;
						last_y_q    <= y_coord;
						ref_q       <= '0;
						present_q   <= 1'b0;
						run_q       <= '0;
					end else if (accept) begin
						run_q <= run_next;
						if (mx == '0) begin
							last_x_q <= x_coord;
							last_y_q <= y_coord;
						end else if (mn == mx) begin
							state_q <= S_TDIV;
						end else begin
							state_q <= S_RDIV;
						end
					end
				end
				S_RDIV: begin
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					if (div_done) begin
						state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					state_q <= (run_q > RUN_W'(1)) ? S_TWAIT : S_CHECK;
				end
				S_TWAIT: begin
					if (div_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q  <= S_IDLE;
					last_x_q <= x_q;
					last_y_q <= y_q;
					if (brk) begin
						anchor_x_q  <= x_q;
						anchor_y_q  <= y_q;
						ref_q       <= '0;
						present_q   <= 1'b0;
						run_q       <= '0;
					end else begin
						ref_q     <= ratio_q;
						present_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= x_coord;
			y_q  <= y_coord;
			mx_q <= mx;
			mn_q <= mn;
		end
		if (accept && first_point) begin
			vertex_x_q <= x_coord;
			vertex_y_q <= y_coord;
		end else if (state_q == S_CHECK && brk) begin
			vertex_x_q <= last_x_q;
			vertex_y_q <= last_y_q;
		end
		if (accept && !first_point && mx != '0 && mn == mx) begin
			ratio_q <= RATIO_ONE;
		end else if (state_q == S_RWAIT && div_done) begin
			ratio_q <= {1'b0, div_quo[RATIO_W-2:0]};
		end
		if (state_q == S_TDIV) begin
			tol_q <= '0;
		end else if (state_q == S_TWAIT && div_done) begin
			tol_q <= div_quo;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex_x  = vertex_x_q;
	assign vertex_y  = vertex_y_q;

	`ASSERT_ALWAYS(a_state_onehot, $onehot(state_q), "sequencer state is not one-hot")
	`ASSERT_CLKD(a_done_in_wait, div_done |-> (state_q == S_RWAIT || state_q == S_TWAIT), "divider result arrived outside a wait state")
	`ASSERT_CLKD(a_ratio_range, (state_q == S_CHECK) |-> (ratio_q <= RATIO_ONE), "slope ratio above one")
	`ASSERT_CLKD(a_idle_divider, (state_q == S_IDLE) |-> !div_busy, "divider busy while idle")

endmodule

`default_nettype wire

[rtl/core/pss_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pss_pkg and assert_macros.svh.
`default_nettype none

module pss_div
	import pss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire div_req_t         req,
	output logic                  busy,
	output logic                  done,
	output logic [QUO_W-1:0]      quotient
);

	`include "assert_macros.svh"

	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;
	logic             fits;

	assign shifted = {rem_q, quo_q[QUO_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign fits    = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.iters;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= req.rem_init;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	`ASSERT_CLKD(a_start_idle, start |-> !busy_q, "divider started while busy")
	`ASSERT_CLKD(a_done_after_busy, done_q |-> $past(busy_q), "done without a preceding run")
	`ASSERT_ALWAYS(a_busy_count, !busy_q || (cnt_q != '0), "busy with an empty count")

endmodule

`default_nettype wire
